@@ rtl/hsvrgb_pkg.sv @@
// ----------------------------------------------------------------------------
// hsvrgb_pkg
// shared widths, constants, sector permutation and byte clamp for the
// hsv to rgb converter
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

    localparam int FRAC_BITS     = 12;
    localparam int HUE_FRAC_BITS = 6;

    localparam int HUE_W = 15;
    localparam int SAT_W = 13;
    localparam int VAL_W = 13;
    localparam int CH_W  = 8;

    localparam int S_TDATA_W = ((HUE_W + SAT_W + VAL_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((3 * CH_W + 7) / 8) * 8;

    localparam int NUM_STAGES = 5;

    // one sector is 60 degrees in hue units
    localparam int SECT_UNITS = 60 * (2 ** HUE_FRAC_BITS);
    localparam int SECT_W     = $clog2(SECT_UNITS + 1);
    localparam int Q_MAX      = (2 ** HUE_W - 1) / SECT_UNITS;
    localparam int Q_W        = $clog2(Q_MAX + 1);
    localparam int NUM_SECT   = 6;
    localparam int SECT_IDX_W = $clog2(NUM_SECT);

    localparam int SV_W  = SAT_W + VAL_W;
    localparam int M_W   = SV_W + 2;
    localparam int P_W   = SV_W + SECT_W;
    localparam int MN_W  = M_W + SECT_W;
    localparam int NUM_W = MN_W + 1;

    // 255 / (60 * 2^H) reduces to 17 / 2^(H + 2)
    localparam int RAMP_MUL   = 17;
    localparam int RAMP_SHIFT = 2 * FRAC_BITS + 2 + HUE_FRAC_BITS;
    localparam int BYTE_MAX   = 255;

    typedef enum logic [1:0] {
        SRC_CHROMA,
        SRC_RAMP,
        SRC_MIN
    } t_src;

    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
    } t_stage_en;

    function automatic t_src perm_sel(input logic [SECT_IDX_W-1:0] sect,
                                      input logic [1:0] chan);
        t_src r;
        t_src g;
        t_src b;
        unique case (sect)
            3'd0:    begin r = SRC_CHROMA; g = SRC_RAMP;   b = SRC_MIN;    end
            3'd1:    begin r = SRC_RAMP;   g = SRC_CHROMA; b = SRC_MIN;    end
            3'd2:    begin r = SRC_MIN;    g = SRC_CHROMA; b = SRC_RAMP;   end
            3'd3:    begin r = SRC_MIN;    g = SRC_RAMP;   b = SRC_CHROMA; end
            3'd4:    begin r = SRC_RAMP;   g = SRC_MIN;    b = SRC_CHROMA; end
            3'd5:    begin r = SRC_CHROMA; g = SRC_MIN;    b = SRC_RAMP;   end
            default: begin r = SRC_MIN;    g = SRC_MIN;    b = SRC_MIN;    end
        endcase
        if (chan == 2'd0) begin
            return r;
        end else if (chan == 2'd1) begin
            return g;
        end else begin
            return b;
        end
    endfunction

    function automatic logic [CH_W-1:0] sat_byte(input logic [63:0] x);
        if (x > 64'(BYTE_MAX)) begin
            return CH_W'(BYTE_MAX);
        end else begin
            return x[CH_W-1:0];
        end
    endfunction

endpackage

@@ rtl/hsvrgb_datapath.sv @@
// ----------------------------------------------------------------------------
// hsvrgb_datapath
// five register stages: sector search and s*v, ramp weight and offset,
// ramp product and scaled offset, ramp sum, byte scaling and permutation
// ----------------------------------------------------------------------------
module hsvrgb_datapath
    import hsvrgb_pkg::*;
(
    input  logic             i_clk,
    input  t_stage_en        i_en,
    input  logic [HUE_W-1:0] i_hue,
    input  logic [SAT_W-1:0] i_saturation,
    input  logic [VAL_W-1:0] i_brightness,
    output logic [CH_W-1:0]  o_red,
    output logic [CH_W-1:0]  o_green,
    output logic [CH_W-1:0]  o_blue
);

    // stage 1
    logic [HUE_W-1:0] r1_hue;
    logic [Q_W-1:0]   r1_q,  n1_q;
    logic [SV_W-1:0]  r1_sv, n1_sv;
    logic [VAL_W-1:0] r1_v;

    always_comb begin
        n1_q = '0;
        for (int k = 1; k <= Q_MAX; k++) begin
            if (i_hue >= HUE_W'(k * SECT_UNITS)) begin
                n1_q = Q_W'(k);
            end
        end
        n1_sv = SV_W'(i_saturation) * SV_W'(i_brightness);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.load[0]) begin
            r1_hue <= i_hue;
            r1_q   <= n1_q;
            r1_sv  <= n1_sv;
            r1_v   <= i_brightness;
        end
    end

    // stage 2
    logic [SECT_W-1:0]     r2_w,    n2_w;
    logic [SECT_IDX_W-1:0] r2_sect, n2_sect;
    logic signed [M_W-1:0] r2_m,    n2_m;
    logic [SV_W-1:0]       r2_sv;
    logic [CH_W-1:0]       r2_cb,   n2_cb;
    logic [HUE_W-1:0]      n2_t;
    logic [SECT_W-1:0]     n2_dist;
    logic [VAL_W+7:0]      n2_vs;

    always_comb begin
        n2_t = r1_hue - HUE_W'(32'(r1_q >> 1) * 2 * SECT_UNITS);
        if (n2_t >= HUE_W'(SECT_UNITS)) begin
            n2_dist = SECT_W'(n2_t - HUE_W'(SECT_UNITS));
        end else begin
            n2_dist = SECT_W'(HUE_W'(SECT_UNITS) - n2_t);
        end
        n2_w = SECT_W'(SECT_UNITS) - n2_dist;
        if (r1_q >= Q_W'(NUM_SECT)) begin
            n2_sect = SECT_IDX_W'(r1_q - Q_W'(NUM_SECT));
        end else begin
            n2_sect = SECT_IDX_W'(r1_q);
        end
        n2_m  = $signed(M_W'(r1_v) << FRAC_BITS) - $signed(M_W'(r1_sv));
        n2_vs = (VAL_W + 8)'(r1_v) * (VAL_W + 8)'(BYTE_MAX);
        n2_cb = sat_byte(64'(n2_vs >> FRAC_BITS));
    end

    always_ff @(posedge i_clk) begin
        if (i_en.load[1]) begin
            r2_w    <= n2_w;
            r2_sect <= n2_sect;
            r2_m    <= n2_m;
            r2_sv   <= r1_sv;
            r2_cb   <= n2_cb;
        end
    end

    // stage 3
    logic [P_W-1:0]         r3_p,  n3_p;
    logic signed [MN_W-1:0] r3_mn, n3_mn;
    logic signed [MN_W-1:0] n3_mext;
    logic [SECT_IDX_W-1:0]  r3_sect;
    logic [CH_W-1:0]        r3_cb;
    logic [CH_W-1:0]        r3_mb, n3_mb;
    logic [M_W+7:0]         n3_ms;

    always_comb begin
        n3_p    = P_W'(r2_sv) * P_W'(r2_w);
        n3_mext = MN_W'(r2_m);
        n3_mn   = n3_mext * $signed(MN_W'(SECT_UNITS));
        n3_ms   = (M_W + 8)'(unsigned'(r2_m)) * (M_W + 8)'(BYTE_MAX);
        if (r2_m <= 0) begin
            n3_mb = '0;
        end else begin
            n3_mb = sat_byte(64'(n3_ms >> (2 * FRAC_BITS)));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.load[2]) begin
            r3_p    <= n3_p;
            r3_mn   <= n3_mn;
            r3_sect <= r2_sect;
            r3_cb   <= r2_cb;
            r3_mb   <= n3_mb;
        end
    end

    // stage 4
    logic signed [NUM_W-1:0] r4_num, n4_num;
    logic [SECT_IDX_W-1:0]   r4_sect;
    logic [CH_W-1:0]         r4_cb;
    logic [CH_W-1:0]         r4_mb;

    always_comb begin
        n4_num = NUM_W'(r3_mn) + $signed(NUM_W'(r3_p));
    end

    always_ff @(posedge i_clk) begin
        if (i_en.load[3]) begin
            r4_num  <= n4_num;
            r4_sect <= r3_sect;
            r4_cb   <= r3_cb;
            r4_mb   <= r3_mb;
        end
    end

    // stage 5
    logic [NUM_W+4:0] n5_rs;
    logic [CH_W-1:0]  n5_xb;
    logic [CH_W-1:0]  n5_ch [3];
    logic [CH_W-1:0]  r5_red, r5_green, r5_blue;

    always_comb begin
        n5_rs = (NUM_W + 5)'(unsigned'(r4_num)) * (NUM_W + 5)'(RAMP_MUL);
        if (r4_num <= 0) begin
            n5_xb = '0;
        end else begin
            n5_xb = sat_byte(64'(n5_rs >> RAMP_SHIFT));
        end
        for (int c = 0; c < 3; c++) begin
            case (perm_sel(r4_sect, 2'(c)))
                SRC_CHROMA: n5_ch[c] = r4_cb;
                SRC_RAMP:   n5_ch[c] = n5_xb;
                default:    n5_ch[c] = r4_mb;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.load[4]) begin
            r5_red   <= n5_ch[0];
            r5_green <= n5_ch[1];
            r5_blue  <= n5_ch[2];
        end
    end

    assign o_red   = r5_red;
    assign o_green = r5_green;
    assign o_blue  = r5_blue;

endmodule

@@ rtl/hsv_to_rgb_converter_top.sv @@
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_top
// throughput: one pixel per cycle while the output side is ready, set by the five-stage datapath pipeline
// each stage holds while it is full and the stage after it cannot take its word, bubbles are squeezed out
// reset (synchronous, active low) clears the stage valid bits only
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_top
    import hsvrgb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,  // hue, saturation, brightness
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [M_TDATA_W-1:0] o_m_axis_tdata   // red, green, blue
);

    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] n_rdy;
    t_stage_en             stage_en;
    logic [CH_W-1:0]       red;
    logic [CH_W-1:0]       green;
    logic [CH_W-1:0]       blue;

    // a stage takes a word when it is empty or its word moves on
    always_comb begin
        n_rdy[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || i_m_axis_tready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            n_rdy[k] = !r_vld[k] || n_rdy[k+1];
        end
        stage_en.load = n_rdy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (n_rdy[0]) begin
                r_vld[0] <= i_s_axis_tvalid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (n_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    hsvrgb_datapath u_datapath (
        .i_clk        (i_clk),
        .i_en         (stage_en),
        .i_hue        (i_s_axis_tdata[HUE_W-1:0]),
        .i_saturation (i_s_axis_tdata[HUE_W+SAT_W-1:HUE_W]),
        .i_brightness (i_s_axis_tdata[HUE_W+SAT_W+VAL_W-1:HUE_W+SAT_W]),
        .o_red        (red),
        .o_green      (green),
        .o_blue       (blue)
    );

    assign o_s_axis_tready = n_rdy[0];
    assign o_m_axis_tvalid = r_vld[NUM_STAGES-1];
    assign o_m_axis_tdata  = M_TDATA_W'({blue, green, red});

endmodule

@@ verif/hsv_to_rgb_converter_checker.sv @@
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_checker
// watches both stream channels of the hsv to rgb converter, works out the
// rgb word for every accepted hsv word in exact integer arithmetic, and
// compares each output word channel by channel against the oldest one due
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_checker
    import hsvrgb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    input  logic                 i_s_axis_tready,
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,  // hue, saturation, brightness
    input  logic                 i_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    input  logic [M_TDATA_W-1:0] i_m_axis_tdata,  // red, green, blue
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_result_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [SAT_W-1:0] sat;
        logic [VAL_W-1:0] val;
        logic [CH_W-1:0]  red;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  blue;
    } t_pixel;

    // every channel level shares this denominator
    localparam longint RGB_DEN = (longint'(1) << (2 * FRAC_BITS)) * SECT_UNITS;

    t_pixel rgb_expected_q [$];

    initial begin
        o_fail_count   = 0;
        o_pending      = 0;
        o_result_count = 0;
    end

    function automatic logic [CH_W-1:0] level_to_byte(input longint level);
        longint q;
        if (level <= 0) begin
            return '0;
        end
        q = (level * BYTE_MAX) / RGB_DEN;
        if (q > longint'(BYTE_MAX)) begin
            return CH_W'(BYTE_MAX);
        end
        return CH_W'(q);
    endfunction

    function automatic t_pixel predict_rgb(input logic [HUE_W-1:0] hue,
                                           input logic [SAT_W-1:0] sat,
                                           input logic [VAL_W-1:0] val);
        t_pixel px;
        longint h;
        longint sect;
        longint ramp_dist;
        longint weight;
        longint sv;
        longint chroma_n;
        longint floor_n;
        longint level [3];
        t_src   src_r;
        t_src   src_g;
        t_src   src_b;
        h         = longint'(hue);
        sect      = (h / SECT_UNITS) % NUM_SECT;
        ramp_dist = (h % (2 * SECT_UNITS)) - SECT_UNITS;
        if (ramp_dist < 0) begin
            ramp_dist = -ramp_dist;
        end
        weight   = SECT_UNITS - ramp_dist;
        sv       = longint'(sat) * longint'(val);
        chroma_n = sv * SECT_UNITS;
        floor_n  = ((longint'(val) << FRAC_BITS) * SECT_UNITS) - chroma_n;
        level[int'(SRC_CHROMA)] = floor_n + chroma_n;
        level[int'(SRC_RAMP)]   = floor_n + sv * weight;
        level[int'(SRC_MIN)]    = floor_n;
        case (sect)
            0: begin
                src_r = SRC_CHROMA; src_g = SRC_RAMP;   src_b = SRC_MIN;
            end
            1: begin
                src_r = SRC_RAMP;   src_g = SRC_CHROMA; src_b = SRC_MIN;
            end
            2: begin
                src_r = SRC_MIN;    src_g = SRC_CHROMA; src_b = SRC_RAMP;
            end
            3: begin
                src_r = SRC_MIN;    src_g = SRC_RAMP;   src_b = SRC_CHROMA;
            end
            4: begin
                src_r = SRC_RAMP;   src_g = SRC_MIN;    src_b = SRC_CHROMA;
            end
            default: begin
                src_r = SRC_CHROMA; src_g = SRC_MIN;    src_b = SRC_RAMP;
            end
        endcase
        px.hue   = hue;
        px.sat   = sat;
        px.val   = val;
        px.red   = level_to_byte(level[int'(src_r)]);
        px.green = level_to_byte(level[int'(src_g)]);
        px.blue  = level_to_byte(level[int'(src_b)]);
        return px;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t mismatch: %s", $realtime, msg);
        o_fail_count++;
    endtask

    task automatic check_channel(input string name, input t_pixel px,
                                 input logic [CH_W-1:0] want,
                                 input logic [CH_W-1:0] got);
        if (got !== want) begin
            report_mismatch($sformatf("%s h=%0d s=%0d v=%0d want %0d got %0d",
                                      name, px.hue, px.sat, px.val, want, got));
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_pixel want;
        if (i_rst_n) begin
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                rgb_expected_q.push_back(predict_rgb(
                    i_s_axis_tdata[HUE_W-1:0],
                    i_s_axis_tdata[HUE_W+SAT_W-1:HUE_W],
                    i_s_axis_tdata[HUE_W+SAT_W+VAL_W-1:HUE_W+SAT_W]));
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                o_result_count++;
                if (rgb_expected_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected output word %h", i_m_axis_tdata));
                end else begin
                    want = rgb_expected_q.pop_front();
                    check_channel("red", want, want.red, i_m_axis_tdata[CH_W-1:0]);
                    check_channel("green", want, want.green, i_m_axis_tdata[2*CH_W-1:CH_W]);
                    check_channel("blue", want, want.blue, i_m_axis_tdata[3*CH_W-1:2*CH_W]);
                end
            end
            o_pending = rgb_expected_q.size();
        end
    end

endmodule

@@ verif/hsv_to_rgb_converter_top_tb.sv @@
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_top_tb
// drives hsv pixels into the converter with random idling on both sides, a
// long output hold-off and drain pauses; corner pixels first, then random
// ones including fields past their nominal range; the checker judges results
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hsvrgb_pkg::*;

    localparam int N_RANDOM    = 1250;
    localparam int IDLE_PCT    = 12;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 4000;
    localparam int TAIL_CYCLES = 2 * NUM_STAGES + 4;
    localparam int HUE_MAX     = NUM_SECT * SECT_UNITS - 1;
    localparam int UNITY       = 1 << FRAC_BITS;
    localparam int HUE_ALL     = (1 << HUE_W) - 1;
    localparam int SAT_ALL     = (1 << SAT_W) - 1;
    localparam int VAL_ALL     = (1 << VAL_W) - 1;

    logic                 i_clk           = 1'b0;
    logic                 i_rst_n         = 1'b0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic [S_TDATA_W-1:0] i_s_axis_tdata  = '0;  // hue, saturation, brightness
    logic                 i_m_axis_tready = 1'b0;
    logic                 o_s_axis_tready;
    logic                 o_m_axis_tvalid;
    logic [M_TDATA_W-1:0] o_m_axis_tdata;       // red, green, blue

    int fail_count;
    int pending;
    int result_count;
    int idle_cycles = 0;
    int n_sent      = 0;
    int n_wide      = 0;
    bit gaps_on     = 1'b1;
    bit rx_hold_req = 1'b0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    hsv_to_rgb_converter_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    hsv_to_rgb_converter_checker checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .i_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_m_axis_tdata  (o_m_axis_tdata),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_result_count  (result_count)
    );

    // stall watchdog
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        wait (idle_cycles >= STALL_LIMIT);
        $display("no word moved for %0d cycles", STALL_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    // output side, with random stalls and one long hold-off
    initial begin
        @(posedge i_clk iff i_rst_n);
        forever begin
            @(posedge i_clk);
            if (rx_hold_req) begin
                i_m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                rx_hold_req = 1'b0;
            end
            i_m_axis_tready <= !(gaps_on && $urandom_range(99) < IDLE_PCT);
        end
    end

    task automatic send_pixel(input int hue, input int sat, input int val);
        while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= S_TDATA_W'({VAL_W'(val), SAT_W'(sat), HUE_W'(hue)});
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        n_sent++;
        if (hue > HUE_MAX || sat > UNITY || val > UNITY) begin
            n_wide++;
        end
    endtask

    task automatic drain_pixels;
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        int hue;
        int sat;
        int val;
        int pick;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // corners: sector edges, grey, black, white, clamps, wrap past 360
        send_pixel(0, UNITY, UNITY);
        send_pixel(1, UNITY, UNITY);
        send_pixel(SECT_UNITS / 2, UNITY, UNITY);
        send_pixel(SECT_UNITS - 1, UNITY, UNITY);
        send_pixel(SECT_UNITS, UNITY, UNITY);
        send_pixel(2 * SECT_UNITS, UNITY, UNITY);
        send_pixel(3 * SECT_UNITS, UNITY, UNITY);
        send_pixel(4 * SECT_UNITS, UNITY, UNITY);
        send_pixel(5 * SECT_UNITS, UNITY, UNITY);
        send_pixel(HUE_MAX, UNITY, UNITY);
        send_pixel(7000, 0, UNITY);
        send_pixel(7000, UNITY, 0);
        send_pixel(0, 0, 0);
        send_pixel(13000, UNITY / 2, UNITY / 2);
        send_pixel(2000, SAT_ALL, UNITY);
        send_pixel(9000, UNITY, VAL_ALL);
        send_pixel(17000, 0, VAL_ALL);
        send_pixel(HUE_MAX + 1, UNITY, UNITY);
        send_pixel(HUE_ALL, UNITY, UNITY);
        send_pixel(HUE_ALL, SAT_ALL, VAL_ALL);
        send_pixel(0, 1, 1);
        drain_pixels();

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == 300) begin
                gaps_on = 1'b0;
            end
            if (i == 500) begin
                gaps_on = 1'b1;
            end
            if (i == 600) begin
                rx_hold_req = 1'b1;
            end
            if (i == 800 || i == 1100) begin
                drain_pixels();
            end
            pick = $urandom_range(99);
            if (pick < 12) begin
                hue = $urandom_range(HUE_ALL);
                sat = $urandom_range(SAT_ALL);
                val = $urandom_range(VAL_ALL);
            end else if (pick < 24) begin
                hue = $urandom_range(HUE_MAX);
                sat = $urandom_range(1) ? UNITY : 0;
                val = $urandom_range(1) ? UNITY : $urandom_range(UNITY);
            end else begin
                hue = $urandom_range(HUE_MAX);
                sat = $urandom_range(UNITY);
                val = $urandom_range(UNITY);
            end
            send_pixel(hue, sat, val);
        end
        drain_pixels();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("pixels sent %0d, of which %0d had a field past its nominal range",
                 n_sent, n_wide);
        $display("output words checked %0d, through idling, a long hold-off and drains",
                 result_count);
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
